// File: rtl/resp_array_token_parser_macros.svh
// Assertion macros used by the parser top level.
`ifndef RESP_ARRAY_TOKEN_PARSER_MACROS_SVH
`define RESP_ARRAY_TOKEN_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RATP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RATP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ratp_pkg.sv
// Types, codes and constants for the array/token parser.
`default_nettype none

package ratp_pkg;

  typedef enum logic [3:0] {
    PH_START,
    PH_WORDS,
    PH_HNUM,
    PH_HLF,
    PH_DOLLAR,
    PH_LNUM,
    PH_LLF,
    PH_DATA,
    PH_SKIP,
    PH_TAIL,
    PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EMPTY,
    ST_HDR,
    ST_FORMAT,
    ST_SHORT,
    ST_NUMBER
  } status_e;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_END,
    KIND_DROP,
    KIND_DONE
  } kind_e;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Results per request: at most three.
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned NRES_W  = 2;

  // Bytes skipped after each element's data.
  localparam logic [1:0] SKIP_BYTES = 2'd2;

  // Result queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data;
    status_e            status;
    logic [COUNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic [NRES_W-1:0]       num;
    res_t [MAX_RES-1:0]      res;
  } bundle_t;

  function automatic res_t make_res(kind_e k, logic [7:0] d, status_e s,
                                    logic [COUNT_W-1:0] c);
    res_t r;
    r.kind   = k;
    r.data   = d;
    r.status = s;
    r.count  = c;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ratp_front.sv
// Front end: takes message bytes, runs the parse state, emits result bundles.
`default_nettype none

module ratp_front #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned MAX_BULK_LEN = 65535
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_data_i,
  input  wire logic              in_no_byte_i,
  input  wire logic              in_last_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output ratp_pkg::bundle_t      q_data_o
);

  localparam int unsigned ELW   = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LW    = $clog2(MAX_BULK_LEN + 1);
  localparam int unsigned ACC_W = (ELW > LW) ? ELW : LW;
  localparam int unsigned PW    = ACC_W + 4;

  ratp_pkg::phase_e   phase_q, phase_d, ph_w;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic               seen_q, seen_d;
  logic [ELW-1:0]     elem_q, elem_d;
  logic [LW-1:0]      bytes_q, bytes_d;
  logic [1:0]         skip_q, skip_d;
  logic               inw_q, inw_d;
  logic [ratp_pkg::COUNT_W-1:0] tok_q, tok_d;
  ratp_pkg::status_e  stop_q, stop_d;

  logic               fire;
  logic               is_ws, is_digit;
  logic [PW-1:0]      prod, bound;
  logic [ratp_pkg::NRES_W-1:0] num;
  ratp_pkg::res_t [ratp_pkg::MAX_RES-1:0] res;
  ratp_pkg::status_e  fin_st;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  assign is_ws    = (in_data_i == ratp_pkg::CH_SPACE) ||
                    ((in_data_i >= ratp_pkg::CH_TAB) && (in_data_i <= ratp_pkg::CH_CR));
  assign is_digit = (in_data_i >= ratp_pkg::CH_ZERO) && (in_data_i <= ratp_pkg::CH_NINE);

  // acc*10 + digit; low nibble of an ASCII digit is its value
  assign prod  = PW'({acc_q, 3'b000}) + PW'({acc_q, 1'b0}) + PW'(in_data_i[3:0]);
  assign bound = (phase_q == ratp_pkg::PH_HNUM) ? PW'(MAX_ELEMENTS) : PW'(MAX_BULK_LEN);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    elem_d  = elem_q;
    bytes_d = bytes_q;
    skip_d  = skip_q;
    inw_d   = inw_q;
    tok_d   = tok_q;
    stop_d  = stop_q;
    num     = '0;
    res     = '0;
    fin_st  = ratp_pkg::ST_OK;
    ph_w    = phase_q;

    if (!in_no_byte_i) begin
      if ((phase_q == ratp_pkg::PH_START) && (in_data_i == ratp_pkg::CH_STAR)) begin
        phase_d = ratp_pkg::PH_HNUM;
        acc_d   = '0;
        seen_d  = 1'b0;
      end else begin
        if (phase_q == ratp_pkg::PH_START) begin
          ph_w = ratp_pkg::PH_WORDS;
        end
        phase_d = ph_w;
        case (ph_w)
          ratp_pkg::PH_WORDS: begin
            if (is_ws) begin
              if (inw_q) begin
                res[num] = ratp_pkg::make_res(ratp_pkg::KIND_END, '0, ratp_pkg::ST_OK, '0);
                num      = num + 1'b1;
                if (tok_d != ratp_pkg::COUNT_MAX) tok_d = tok_d + 1'b1;
                inw_d    = 1'b0;
              end
            end else begin
              res[num] = ratp_pkg::make_res(ratp_pkg::KIND_BYTE, in_data_i,
                                            ratp_pkg::ST_OK, '0);
              num      = num + 1'b1;
              inw_d    = 1'b1;
            end
          end
          ratp_pkg::PH_HNUM, ratp_pkg::PH_LNUM: begin
            if (in_data_i == ratp_pkg::CH_CR) begin
              if (seen_q) begin
                phase_d = (ph_w == ratp_pkg::PH_HNUM) ? ratp_pkg::PH_HLF : ratp_pkg::PH_LLF;
              end else begin
                stop_d  = ratp_pkg::ST_NUMBER;
                phase_d = ratp_pkg::PH_ERR;
              end
            end else if (!is_digit) begin
              stop_d  = ratp_pkg::ST_NUMBER;
              phase_d = ratp_pkg::PH_ERR;
            end else begin
              acc_d  = prod[ACC_W-1:0];
              seen_d = 1'b1;
              if (prod > bound) begin
                stop_d  = ratp_pkg::ST_NUMBER;
                phase_d = ratp_pkg::PH_ERR;
              end
            end
          end
          ratp_pkg::PH_HLF: begin
            if (in_data_i != ratp_pkg::CH_LF) begin
              stop_d  = ratp_pkg::ST_NUMBER;
              phase_d = ratp_pkg::PH_ERR;
            end else begin
              elem_d  = acc_q[ELW-1:0];
              phase_d = (acc_q != '0) ? ratp_pkg::PH_DOLLAR : ratp_pkg::PH_TAIL;
            end
          end
          ratp_pkg::PH_DOLLAR: begin
            if (in_data_i != ratp_pkg::CH_DOLLAR) begin
              stop_d  = ratp_pkg::ST_FORMAT;
              phase_d = ratp_pkg::PH_ERR;
            end else begin
              acc_d   = '0;
              seen_d  = 1'b0;
              phase_d = ratp_pkg::PH_LNUM;
            end
          end
          ratp_pkg::PH_LLF: begin
            if (in_data_i != ratp_pkg::CH_LF) begin
              stop_d  = ratp_pkg::ST_NUMBER;
              phase_d = ratp_pkg::PH_ERR;
            end else begin
              bytes_d = acc_q[LW-1:0];
              if (acc_q == '0) begin
                // empty element closes on its LF
                res[num] = ratp_pkg::make_res(ratp_pkg::KIND_END, '0, ratp_pkg::ST_OK, '0);
                num      = num + 1'b1;
                if (tok_d != ratp_pkg::COUNT_MAX) tok_d = tok_d + 1'b1;
                if (elem_d != '0) elem_d = elem_d - 1'b1;
                skip_d   = ratp_pkg::SKIP_BYTES;
                phase_d  = ratp_pkg::PH_SKIP;
              end else begin
                phase_d = ratp_pkg::PH_DATA;
              end
            end
          end
          ratp_pkg::PH_DATA: begin
            res[num] = ratp_pkg::make_res(ratp_pkg::KIND_BYTE, in_data_i,
                                          ratp_pkg::ST_OK, '0);
            num      = num + 1'b1;
            if (bytes_d != '0) bytes_d = bytes_d - 1'b1;
            if (bytes_d == '0) begin
              res[num] = ratp_pkg::make_res(ratp_pkg::KIND_END, '0, ratp_pkg::ST_OK, '0);
              num      = num + 1'b1;
              if (tok_d != ratp_pkg::COUNT_MAX) tok_d = tok_d + 1'b1;
              if (elem_d != '0) elem_d = elem_d - 1'b1;
              skip_d   = ratp_pkg::SKIP_BYTES;
              phase_d  = ratp_pkg::PH_SKIP;
            end
          end
          ratp_pkg::PH_SKIP: begin
            if (skip_d != '0) skip_d = skip_d - 1'b1;
            if (skip_d == '0) begin
              phase_d = (elem_q != '0) ? ratp_pkg::PH_DOLLAR : ratp_pkg::PH_TAIL;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (in_last_i) begin
      unique case (phase_d)
        ratp_pkg::PH_START: fin_st = ratp_pkg::ST_EMPTY;
        ratp_pkg::PH_WORDS: begin
          if (inw_d) begin
            res[num] = ratp_pkg::make_res(ratp_pkg::KIND_END, '0, ratp_pkg::ST_OK, '0);
            num      = num + 1'b1;
            if (tok_d != ratp_pkg::COUNT_MAX) tok_d = tok_d + 1'b1;
          end
          fin_st = ratp_pkg::ST_OK;
        end
        ratp_pkg::PH_HNUM, ratp_pkg::PH_HLF: fin_st = ratp_pkg::ST_HDR;
        ratp_pkg::PH_DOLLAR, ratp_pkg::PH_LNUM, ratp_pkg::PH_LLF: fin_st = ratp_pkg::ST_SHORT;
        ratp_pkg::PH_DATA: begin
          res[num] = ratp_pkg::make_res(ratp_pkg::KIND_DROP, '0, ratp_pkg::ST_OK, '0);
          num      = num + 1'b1;
          fin_st   = ratp_pkg::ST_SHORT;
        end
        ratp_pkg::PH_SKIP: fin_st = (elem_d != '0) ? ratp_pkg::ST_SHORT : ratp_pkg::ST_OK;
        ratp_pkg::PH_ERR:  fin_st = stop_d;
        default:           fin_st = ratp_pkg::ST_OK;
      endcase
      res[num] = ratp_pkg::make_res(ratp_pkg::KIND_DONE, '0, fin_st, tok_d);
      num      = num + 1'b1;
      // back to the start-of-message state
      phase_d = ratp_pkg::PH_START;
      acc_d   = '0;
      seen_d  = 1'b0;
      elem_d  = '0;
      bytes_d = '0;
      skip_d  = '0;
      inw_d   = 1'b0;
      tok_d   = '0;
      stop_d  = ratp_pkg::ST_OK;
    end
  end

  assign q_push_o     = fire && (num != '0);
  assign q_data_o.num = num;
  assign q_data_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ratp_pkg::PH_START;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      elem_q  <= '0;
      bytes_q <= '0;
      skip_q  <= '0;
      inw_q   <= 1'b0;
      tok_q   <= '0;
      stop_q  <= ratp_pkg::ST_OK;
    end else if (fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      elem_q  <= elem_d;
      bytes_q <= bytes_d;
      skip_q  <= skip_d;
      inw_q   <= inw_d;
      tok_q   <= tok_d;
      stop_q  <= stop_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ratp_queue.sv
// Small FIFO of result bundles between front and back.
`default_nettype none

module ratp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ratp_pkg::bundle_t push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output ratp_pkg::bundle_t      head_o,
  output logic                   empty_o
);

  localparam logic [ratp_pkg::QPTR_W-1:0] PTR_LAST = ratp_pkg::QPTR_W'(ratp_pkg::QDEPTH - 1);
  localparam logic [ratp_pkg::QCNT_W-1:0] CNT_FULL = ratp_pkg::QCNT_W'(ratp_pkg::QDEPTH);

  ratp_pkg::bundle_t mem_q [ratp_pkg::QDEPTH];
  logic [ratp_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [ratp_pkg::QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ratp_back.sv
// Back end: unpacks bundles into the output register, one result per cycle while out_ready_i is high.
`default_nettype none

module ratp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire ratp_pkg::bundle_t head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output ratp_pkg::res_t         out_res_o,
  output logic                   out_last_o
);

  logic [ratp_pkg::NRES_W-1:0] idx_q;
  logic                        valid_q;
  ratp_pkg::res_t              res_q;
  logic                        last_q;
  logic                        load;
  logic                        at_last;

  assign at_last = (idx_q == (head_i.num - 1'b1));
  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o   = load && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_last ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.res[idx_q];
      last_q <= at_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// File: rtl/resp_array_token_parser.sv
// Top level of the array/bulk-string token parser.
// Splits a command message, one byte per request, into tokens. A message that
// starts with '*' is read as an array header (decimal count, CR LF) followed by
// elements '$', decimal length, CR LF, data bytes and two skipped bytes; any
// other first byte selects whitespace-separated words. Token bytes leave as
// they arrive (tuser = byte), a token end follows each token, a drop marks a
// data token cut off by the message end, and a done result closes every
// message with the token count and a status (0 ok, 1 empty, 2 header
// unfinished, 3 format, 4 short, 5 bad number). tlast on the output marks the
// final result caused by one input request. Rate: the front parser takes one
// byte per cycle while the queue has room; the output side delivers one result
// per cycle while m_axis_tready is high, so a request that produces two or
// three results (data byte plus token end, message end) holds the output for
// each of them in turn. A four-bundle queue between the parser and the output
// stage absorbs those bursts; input stalls only when it fills. The first
// result of a request is registered in the queue, then in the output register.
`default_nettype none

`include "resp_array_token_parser_macros.svh"

module resp_array_token_parser #(
  parameter int unsigned MAX_ELEMENTS = 1024,   // 1 .. 65535
  parameter int unsigned MAX_BULK_LEN = 65535   // 1 .. 16777215
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input requests
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] no_byte
  input  wire logic        s_axis_tlast,   // last_of_message
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] token_byte, [10:8] end_status,
                                           // [21:11] token_count, [23:22] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // last_result
);

  logic              q_push, q_full, q_pop, q_empty;
  ratp_pkg::bundle_t q_in, q_head;
  ratp_pkg::res_t    out_res;

  // Parser: classifies each byte and builds the results it causes.
  ratp_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_BULK_LEN (MAX_BULK_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_no_byte_i (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_in)
  );

  // Decouples parser from output backpressure.
  ratp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  // Serializes each bundle into the registered output.
  ratp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_res_o    (out_res),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_res.count, out_res.status, out_res.data};
  assign m_axis_tuser = out_res.kind;

  // done is always the final result of its request
  `RATP_ASSERT_NOW(a_done_last, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser == ratp_pkg::KIND_DONE), m_axis_tlast,
    "done result without tlast")
  // only done carries status and count
  `RATP_ASSERT_NOW(a_nondone_clean, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser != ratp_pkg::KIND_DONE), m_axis_tdata[21:8] == 14'd0,
    "status or count set on a non-done result")
  // parser never pushes into a full queue
  `RATP_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, q_push, !q_full,
    "push into full result queue")
  // a pop always hands over a bundle that exists
  `RATP_ASSERT_NOW(a_no_underflow, clk_i, rst_ni, q_pop, !q_empty,
    "pop from empty result queue")

endmodule

`default_nettype wire
